// ===== sv/xru_pkg.sv =====
// Shared types, character constants and entity-name tables for the XML
// reference unescaper. Used by every module of the block; depends on nothing.
package xru_pkg;

    // Default number of pending result runs between the decoder and the serializer.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Error codes carried with every result word.
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_ENTITY    = 3'd1,
        ERR_MALFORMED = 3'd2,
        ERR_LARGE     = 3'd3,
        ERR_FORBIDDEN = 3'd4
    } t_err;

    // One run: the words that a single input byte gives (one to four).
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        logic            valid;
        t_err            err;
        logic            seg_end;
    } t_run;

    // Characters that steer the decoder.
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Code point limits and UTF-8 framing.
    localparam logic [20:0] CODE_MAX   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] NONCHAR_LO = 21'h00FFFE;
    localparam logic [20:0] NONCHAR_HI = 21'h00FFFF;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;

    // The five predefined entities: spelling, length and replacement byte.
    localparam int NUM_NAMES = 5;
    localparam logic [7:0] NAME_CHARS [NUM_NAMES][4] = '{
        '{"a", "m", "p", 8'h00},
        '{"l", "t", 8'h00, 8'h00},
        '{"g", "t", 8'h00, 8'h00},
        '{"a", "p", "o", "s"},
        '{"q", "u", "o", "t"}
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
    localparam logic [7:0] NAME_OUT [NUM_NAMES] = '{8'h26, 8'h3C, 8'h3E, 8'h27, 8'h22};

endpackage

// ===== sv/xru_if.sv =====
// Valid/ready channel interfaces for the input bytes and the result words.
// Depends on nothing.
interface xru_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       attribute_mode;
    logic       segment_last;

    modport source (output valid, in_byte, attribute_mode, segment_last, input ready);
    modport sink (input valid, in_byte, attribute_mode, segment_last, output ready);
endinterface

interface xru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] error_code;
    logic       run_last;
    logic       segment_end;

    modport source (output valid, out_byte, byte_valid, error_code, run_last, segment_end,
                    input ready);
    modport sink (input valid, out_byte, byte_valid, error_code, run_last, segment_end,
                  output ready);
endinterface

// ===== sv/xru_front.sv =====
// Decoder front end: accepts one input byte per cycle unless the queue is full,
// tracks the reference state and builds each byte's run. Uses xru_pkg, xru_if.
module xru_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xru_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output xru_pkg::t_run o_run
);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_AMP   = 3'd1,
        PH_HASH  = 3'd2,
        PH_DEC   = 3'd3,
        PH_HEX   = 3'd4,
        PH_NAME  = 3'd5
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [20:0]   r_code, n_code;
    logic          r_seen, n_seen;
    logic [2:0]    r_cnt, n_cnt;
    logic [xru_pkg::NUM_NAMES-1:0] r_mask, n_mask;

    logic          accept;
    logic          have;
    logic          do_name;
    logic          do_num;
    logic [7:0]    c;

    assign c        = i_in.in_byte;
    assign i_in.ready = !i_full;
    assign accept   = i_in.valid && !i_full;
    assign o_push   = accept && have;

    // Entity name matching against the names still possible.
    logic [2:0]    sel_cnt;
    logic [xru_pkg::NUM_NAMES-1:0] sel_mask, name_cont;
    logic          name_hit;
    logic [7:0]    hit_byte;

    assign sel_cnt  = (r_phase == PH_AMP) ? 3'd0 : r_cnt;
    assign sel_mask = (r_phase == PH_AMP) ? '1 : r_mask;

    always_comb begin
        name_hit  = 1'b0;
        hit_byte  = '0;
        name_cont = '0;
        for (int i = 0; i < xru_pkg::NUM_NAMES; i++) begin
            if (sel_mask[i] && c == xru_pkg::CH_SEMI && sel_cnt == xru_pkg::NAME_LEN[i]) begin
                name_hit = 1'b1;
                hit_byte = xru_pkg::NAME_OUT[i];
            end
            if (sel_mask[i] && c != xru_pkg::CH_SEMI && sel_cnt < xru_pkg::NAME_LEN[i] &&
                xru_pkg::NAME_CHARS[i][sel_cnt[1:0]] == c) begin
                name_cont[i] = 1'b1;
            end
        end
    end

    // Digit decoding and accumulation; the sum is wide enough to catch overflow.
    logic          hex_mode;
    logic          dig_ok;
    logic [3:0]    dig_val;
    logic [24:0]   acc;

    assign hex_mode = (r_phase == PH_HEX);

    always_comb begin
        dig_ok  = 1'b1;
        dig_val = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            dig_val = 4'(c - 8'h30);
        end else if (hex_mode && c >= 8'h61 && c <= 8'h66) begin
            dig_val = 4'(c - 8'h57);
        end else if (hex_mode && c >= 8'h41 && c <= 8'h46) begin
            dig_val = 4'(c - 8'h37);
        end else begin
            dig_ok = 1'b0;
        end
    end

    always_comb begin
        if (hex_mode) begin
            acc = (25'(r_code) << 4) + 25'(dig_val);
        end else begin
            acc = (25'(r_code) << 3) + (25'(r_code) << 1) + 25'(dig_val);
        end
    end

    // Validity check and UTF-8 encoding of the accumulated code point.
    logic            forbidden;
    logic [3:0][7:0] enc_bytes;
    logic [1:0]      enc_idx;

    always_comb begin
        forbidden = (r_code < 21'h20 && r_code != 21'(xru_pkg::CH_TAB) &&
                     r_code != 21'(xru_pkg::CH_LF) && r_code != 21'(xru_pkg::CH_CR)) ||
                    (r_code >= xru_pkg::SURR_LO && r_code <= xru_pkg::SURR_HI) ||
                    r_code == xru_pkg::NONCHAR_LO || r_code == xru_pkg::NONCHAR_HI;
        enc_bytes = '0;
        if (r_code < 21'h80) begin
            enc_idx      = 2'd0;
            enc_bytes[0] = r_code[7:0];
        end else if (r_code < 21'h800) begin
            enc_idx      = 2'd1;
            enc_bytes[0] = 8'(r_code >> 6) | xru_pkg::UTF8_LEAD2;
            enc_bytes[1] = (r_code[7:0] & xru_pkg::UTF8_MASK) | xru_pkg::UTF8_CONT;
        end else if (r_code < 21'h10000) begin
            enc_idx      = 2'd2;
            enc_bytes[0] = 8'(r_code >> 12) | xru_pkg::UTF8_LEAD3;
            enc_bytes[1] = (8'(r_code >> 6) & xru_pkg::UTF8_MASK) | xru_pkg::UTF8_CONT;
            enc_bytes[2] = (r_code[7:0] & xru_pkg::UTF8_MASK) | xru_pkg::UTF8_CONT;
        end else begin
            enc_idx      = 2'd3;
            enc_bytes[0] = 8'(r_code >> 18) | xru_pkg::UTF8_LEAD4;
            enc_bytes[1] = (8'(r_code >> 12) & xru_pkg::UTF8_MASK) | xru_pkg::UTF8_CONT;
            enc_bytes[2] = (8'(r_code >> 6) & xru_pkg::UTF8_MASK) | xru_pkg::UTF8_CONT;
            enc_bytes[3] = (r_code[7:0] & xru_pkg::UTF8_MASK) | xru_pkg::UTF8_CONT;
        end
    end

    // Next state and the run for this byte.
    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_seen   = r_seen;
        n_cnt    = r_cnt;
        n_mask   = r_mask;
        have     = 1'b0;
        do_name  = 1'b0;
        do_num   = 1'b0;
        o_run.last_idx = 2'd0;
        o_run.bytes    = '0;
        o_run.valid    = 1'b0;
        o_run.err      = xru_pkg::ERR_OK;
        o_run.seg_end  = i_in.segment_last;

        case (r_phase)
            PH_PLAIN: begin
                if (c == xru_pkg::CH_AMP) begin
                    n_phase = PH_AMP;
                    n_code  = '0;
                    n_seen  = 1'b0;
                    n_cnt   = '0;
                end else begin
                    have        = 1'b1;
                    o_run.valid = 1'b1;
                    if (i_in.attribute_mode && (c == xru_pkg::CH_TAB ||
                        c == xru_pkg::CH_LF || c == xru_pkg::CH_CR)) begin
                        o_run.bytes[0] = xru_pkg::CH_SPACE;
                    end else begin
                        o_run.bytes[0] = c;
                    end
                end
            end
            PH_AMP: begin
                if (c == xru_pkg::CH_HASH) begin
                    n_phase = PH_HASH;
                    n_code  = '0;
                    n_seen  = 1'b0;
                end else begin
                    do_name = 1'b1;
                end
            end
            PH_NAME: begin
                do_name = 1'b1;
            end
            PH_HASH: begin
                if (c == xru_pkg::CH_X) begin
                    n_phase = PH_HEX;
                    n_code  = '0;
                    n_seen  = 1'b0;
                end else begin
                    do_num = 1'b1;
                end
            end
            PH_DEC, PH_HEX: begin
                do_num = 1'b1;
            end
            default: begin
                n_phase = PH_PLAIN;
                n_code  = '0;
                n_seen  = 1'b0;
                n_cnt   = '0;
            end
        endcase

        // Named entity step.
        if (do_name) begin
            if (name_hit) begin
                n_phase = PH_PLAIN;
                n_code  = '0;
                n_seen  = 1'b0;
                n_cnt   = '0;
                have    = 1'b1;
                o_run.valid    = 1'b1;
                o_run.bytes[0] = hit_byte;
            end else if (|name_cont) begin
                n_cnt   = sel_cnt + 3'd1;
                n_mask  = name_cont;
                n_phase = PH_NAME;
            end else begin
                n_phase = PH_PLAIN;
                n_code  = '0;
                n_seen  = 1'b0;
                n_cnt   = '0;
                have    = 1'b1;
                o_run.err = xru_pkg::ERR_ENTITY;
            end
        end

        // Numeric reference step.
        if (do_num) begin
            if (dig_ok) begin
                if (acc > 25'(xru_pkg::CODE_MAX)) begin
                    n_phase = PH_PLAIN;
                    n_code  = '0;
                    n_seen  = 1'b0;
                    n_cnt   = '0;
                    have    = 1'b1;
                    o_run.err = xru_pkg::ERR_LARGE;
                end else begin
                    n_code  = acc[20:0];
                    n_seen  = 1'b1;
                    n_phase = hex_mode ? PH_HEX : PH_DEC;
                end
            end else begin
                n_phase = PH_PLAIN;
                n_code  = '0;
                n_seen  = 1'b0;
                n_cnt   = '0;
                have    = 1'b1;
                if (c == xru_pkg::CH_SEMI && r_seen) begin
                    if (forbidden) begin
                        o_run.err = xru_pkg::ERR_FORBIDDEN;
                    end else begin
                        o_run.valid    = 1'b1;
                        o_run.bytes    = enc_bytes;
                        o_run.last_idx = enc_idx;
                    end
                end else begin
                    o_run.err = xru_pkg::ERR_MALFORMED;
                end
            end
        end

        // Segment end closes any open reference and never leaves the run empty.
        if (i_in.segment_last) begin
            if (n_phase == PH_AMP || n_phase == PH_NAME) begin
                have      = 1'b1;
                o_run.err = xru_pkg::ERR_ENTITY;
            end else if (n_phase != PH_PLAIN) begin
                have      = 1'b1;
                o_run.err = xru_pkg::ERR_MALFORMED;
            end
            if (n_phase != PH_PLAIN) begin
                n_phase = PH_PLAIN;
                n_code  = '0;
                n_seen  = 1'b0;
                n_cnt   = '0;
            end
            have = 1'b1;
        end
    end

    // Reference state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_code  <= '0;
            r_seen  <= 1'b0;
            r_cnt   <= '0;
            r_mask  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
            r_mask  <= n_mask;
        end
    end

endmodule

// ===== sv/xru_queue.sv =====
// Short queue of pending runs between the decoder and the serializer.
// Uses xru_pkg for the run type.
module xru_queue #(
    parameter int DEPTH = xru_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xru_pkg::t_run i_run,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output xru_pkg::t_run o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xru_pkg::t_run r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== sv/xru_back.sv =====
// Serializer back end: walks the run at the head of the queue and presents one
// result word per cycle, while the output is ready, in an output register. Uses xru_pkg, xru_if.
module xru_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  xru_pkg::t_run i_head,
    output logic          o_pop,
    xru_out_if.source     o_out
);

    logic         r_valid;
    logic [7:0]   r_byte;
    logic         r_bv;
    xru_pkg::t_err r_err;
    logic         r_run_last;
    logic         r_seg_end;
    logic [1:0]   r_pos;

    logic         take;
    logic         is_last;

    assign take    = (!r_valid || o_out.ready) && !i_empty;
    assign is_last = (r_pos == i_head.last_idx);
    assign o_pop   = take && is_last;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.byte_valid  = r_bv;
    assign o_out.error_code  = r_err;
    assign o_out.run_last    = r_run_last;
    assign o_out.segment_end = r_seg_end;

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte     <= i_head.bytes[r_pos];
            r_bv       <= i_head.valid;
            r_err      <= i_head.err;
            r_run_last <= is_last;
            r_seg_end  <= i_head.seg_end;
        end
    end

    // Output valid and position within the current run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_pos   <= is_last ? 2'd0 : r_pos + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/xml_reference_unescaper.sv =====
// XML reference unescaper: takes one raw byte per cycle and returns its decoded
// words. Depends on xru_pkg, xru_if, xru_front, xru_queue and xru_back.
//
// The block accepts one input byte every clock cycle unless its queue is full.
// Plain bytes and named entities give one result word each; a numeric reference
// gives one to four UTF-8 words, released one per cycle by the serializer while
// the output is ready. A queue of QUEUE_DEPTH runs between the decoder and the
// serializer absorbs these bursts and output stalls; input ready drops only when
// that queue is full. When nothing waits ahead of it, a byte's run is written
// into the queue as the byte is accepted and then loaded into the output
// register, where its first word can be taken.
module xml_reference_unescaper #(
    parameter int QUEUE_DEPTH = xru_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xru_in_if.sink    i_in,
    xru_out_if.source o_out
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    xru_pkg::t_run run;
    xru_pkg::t_run head;

    // Decoder: reference tracking and run building.
    xru_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_run   (run)
    );

    // Pending runs.
    xru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Serializer: one result word per cycle while the output is ready.
    xru_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
